FILE: rtl/hsa_pkg.sv
// Shared types and constants of the HSV saturation adjust pipeline.
// No dependencies; imported by every other file in rtl.
`default_nettype none

package hsa_pkg;

  localparam int CH_W      = 16;         // color channel width
  localparam int Q_W       = 17;         // quotient width, Q1.16 up to 1.0
  localparam int DIV_STEPS = Q_W;        // one quotient bit per divider stage
  localparam int CFG_W     = 18;         // signed Q2.16 register width
  localparam int HUE_W     = 19;         // sector (3 bits) + 16-bit fraction
  localparam int HUE_WRAP  = 6 * 65536;  // hue period in Q16 sectors

  // register indexes of the configuration port
  localparam logic REG_VIBRANCE   = 1'b0;
  localparam logic REG_SATURATION = 1'b1;

  // hue sector base: which channel is the maximum
  localparam logic [2:0] BASE_RED   = 3'd0;
  localparam logic [2:0] BASE_GREEN = 3'd2;
  localparam logic [2:0] BASE_BLUE  = 3'd4;

  // configuration handed to the back end
  typedef struct packed {
    logic signed [CFG_W-1:0] vib;
    logic signed [CFG_W-1:0] sat;
  } cfg_t;

  // per-pixel information that rides along with the divider
  typedef struct packed {
    logic [CH_W-1:0] mx;     // value V
    logic [2:0]      base;   // hue sector base
    logic            neg;    // hue numerator negative
    logic            grey;   // delta is zero
    logic            black;  // max is zero
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/hsa_front.sv
// Front stage: max, min, delta and hue numerator of one pixel.
// Depends on hsa_pkg.
`default_nettype none

module hsa_front
  import hsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CH_W-1:0]      red,
  input  wire logic [CH_W-1:0]      green,
  input  wire logic [CH_W-1:0]      blue,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output side_t                     side,
  output logic [1:0][CH_W-1:0]      num,   // lane 0 saturation, lane 1 hue
  output logic [1:0][CH_W-1:0]      den
);

  logic [CH_W-1:0]   mx, mn, delta, mag;
  logic signed [CH_W:0] hnum;
  logic [2:0]        base;
  logic              vld;

  // max/min with red winning ties, then green
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    if (red == mx) begin
      hnum = $signed({1'b0, green}) - $signed({1'b0, blue});
      base = BASE_RED;
    end else if (green == mx) begin
      hnum = $signed({1'b0, blue}) - $signed({1'b0, red});
      base = BASE_GREEN;
    end else begin
      hnum = $signed({1'b0, red}) - $signed({1'b0, green});
      base = BASE_BLUE;
    end
    mag = hnum[CH_W] ? CH_W'(-hnum) : hnum[CH_W-1:0];
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side.mx    <= mx;
      side.base  <= base;
      side.neg   <= hnum[CH_W];
      side.grey  <= (delta == '0);
      side.black <= (mx == '0);
      num[0]     <= delta;
      den[0]     <= mx;
      num[1]     <= mag;
      den[1]     <= delta;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hsa_div.sv
// Pipelined restoring divider, two lanes: floor(num * 2^16 / den), one bit a stage.
// Depends on hsa_pkg. num <= den is assumed; den zero gives a don't-care result.
`default_nettype none

module hsa_div
  import hsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire side_t                in_side,
  input  wire logic [1:0][CH_W-1:0] num,
  input  wire logic [1:0][CH_W-1:0] den,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output side_t                     out_side,
  output logic [1:0][Q_W-1:0]       quo,
  output logic                      hue_inexact  // lane 1 remainder nonzero
);

  logic                  vld  [DIV_STEPS];
  logic                  en   [DIV_STEPS];
  side_t                 sd   [DIV_STEPS];
  logic [1:0][Q_W-1:0]   rem  [DIV_STEPS];
  logic [1:0][CH_W-1:0]  dv   [DIV_STEPS];
  logic [1:0][Q_W-1:0]   qt   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 src_vld;
    side_t                src_sd;
    logic [1:0][Q_W-1:0]  src_rem, src_q, rem_next, q_next;
    logic [1:0][CH_W-1:0] src_d;

    // stage source: pipeline input or previous stage
    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_sd  = in_side;
      assign src_d   = den;
      assign src_q   = '0;
      assign src_rem = {{1'b0, num[1]}, {1'b0, num[0]}};
    end else begin : g_next
      assign src_vld = vld[k-1];
      assign src_sd  = sd[k-1];
      assign src_d   = dv[k-1];
      assign src_q   = qt[k-1];
      assign src_rem = rem[k-1];
    end

    if (k == DIV_STEPS-1) begin : g_last_en
      assign en[k] = !vld[k] || out_ready;
    end else begin : g_mid_en
      assign en[k] = !vld[k] || en[k+1];
    end

    // one compare/subtract per lane; shift except after the last bit
    always_comb begin
      logic          ge;
      logic [Q_W-1:0] diff;
      logic [CH_W-1:0] r16;
      for (int l = 0; l < 2; l++) begin
        diff = src_rem[l] - {1'b0, src_d[l]};
        ge   = (src_rem[l] >= {1'b0, src_d[l]});
        r16  = ge ? diff[CH_W-1:0] : src_rem[l][CH_W-1:0];
        rem_next[l] = (k == DIV_STEPS-1) ? {1'b0, r16} : {r16, 1'b0};
        q_next[l]   = src_q[l];
        q_next[l][DIV_STEPS-1-k] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && src_vld) begin
        sd[k]  <= src_sd;
        dv[k]  <= src_d;
        qt[k]  <= q_next;
        rem[k] <= rem_next;
      end
    end
  end

  assign in_ready    = en[0];
  assign out_valid   = vld[DIV_STEPS-1];
  assign out_side    = sd[DIV_STEPS-1];
  assign quo         = qt[DIV_STEPS-1];
  assign hue_inexact = (rem[DIV_STEPS-1][1] != '0);

endmodule

`default_nettype wire

FILE: rtl/hsa_back.sv
// Back end: hue assembly, new saturation, HSV to RGB, output register.
// Depends on hsa_pkg. Six register stages, the last one drives the output.
`default_nettype none

module hsa_back
  import hsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire side_t                side,
  input  wire logic [1:0][Q_W-1:0]  quo,
  input  wire logic                 hue_inexact,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CH_W-1:0]           red,
  output logic [CH_W-1:0]           green,
  output logic [CH_W-1:0]           blue
);

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  // bubbles collapse: a stage moves when empty or when the next one moves
  assign en6 = !v6 || out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: hue from sector base and quotient, with wrap
  logic [Q_W:0]            hmag;
  logic signed [HUE_W:0]   hraw;
  logic [HUE_W-1:0]        hue0, hue1;
  logic [Q_W-1:0]          s1;
  logic [CH_W-1:0]         mx1;

  always_comb begin
    hmag = {1'b0, quo[1]} + {{Q_W{1'b0}}, hue_inexact};
    if (side.neg) begin
      hraw = $signed({1'b0, side.base, 16'h0000}) - $signed({2'b00, hmag});
      if (hraw < 0) hraw = hraw + (HUE_W+1)'(HUE_WRAP);
    end else begin
      hraw = $signed({1'b0, side.base, 16'h0000}) + $signed({3'b000, quo[1]});
    end
    hue0 = (side.grey || side.black) ? '0 : hraw[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      hue1 <= hue0;
      s1   <= side.black ? '0 : quo[0];
      mx1  <= side.mx;
    end
  end

  // stage 2: slope times saturation
  logic signed [CFG_W:0]   slope, icpt0;
  logic signed [CFG_W:0]   icpt2;
  logic signed [2*CFG_W:0] prod2;
  logic [HUE_W-1:0]        hue2;
  logic [CH_W-1:0]         mx2;

  assign slope = $signed((CFG_W+1)'(65536)) - $signed({cfg.vib[CFG_W-1], cfg.vib});
  assign icpt0 = $signed({cfg.vib[CFG_W-1], cfg.vib}) + $signed({cfg.sat[CFG_W-1], cfg.sat});

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      prod2 <= (2*CFG_W+1)'(slope * $signed({1'b0, s1}));
      icpt2 <= icpt0;
      hue2  <= hue1;
      mx2   <= mx1;
    end
  end

  // stage 3: intercept plus product, clamp to [0, 2^32]
  logic signed [2*CFG_W+1:0] exact;
  logic [Q_W-1:0]            ns0, ns3;
  logic [HUE_W-1:0]          hue3;
  logic [CH_W-1:0]           mx3;

  always_comb begin
    exact = $signed({icpt2, 16'h0000}) + $signed({prod2[2*CFG_W], prod2});
    if (exact < 0) begin
      ns0 = '0;
    end else if (exact > $signed((2*CFG_W+2)'(64'h1_0000_0000))) begin
      ns0 = Q_W'(65536);
    end else begin
      ns0 = exact[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ns3  <= ns0;
      hue3 <= hue2;
      mx3  <= mx2;
    end
  end

  // stage 4: saturation times fraction terms, and p
  logic [Q_W-1:0]    fcomp;
  logic [2*Q_W-1:0]  pp_full;
  logic [2*Q_W-1:0]  a2_full;
  logic [32:0]       a1_4, a2_4;
  logic [CH_W-1:0]   p4, mx4;
  logic [2:0]        sec4;
  logic              nz4;

  assign fcomp   = Q_W'(65536) - {1'b0, hue3[15:0]};
  assign pp_full = {1'b0, mx3} * (Q_W'(65536) - ns3);
  assign a2_full = ns3 * fcomp;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      a1_4 <= 33'(ns3 * hue3[15:0]);
      a2_4 <= a2_full[32:0];
      p4   <= pp_full[31:16];
      mx4  <= mx3;
      sec4 <= hue3[HUE_W-1:16];
      nz4  <= (ns3 != '0);
    end
  end

  // stage 5: q and t
  logic [32:0]     qm, tm;
  logic [48:0]     qprod, tprod;
  logic [CH_W-1:0] p5, q5, t5, mx5;
  logic [2:0]      sec5;
  logic            nz5;

  assign qm    = 33'h1_0000_0000 - a1_4;
  assign tm    = 33'h1_0000_0000 - a2_4;
  assign qprod = mx4 * qm;
  assign tprod = mx4 * tm;

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      q5   <= qprod[47:32];
      t5   <= tprod[47:32];
      p5   <= p4;
      mx5  <= mx4;
      sec5 <= sec4;
      nz5  <= nz4;
    end
  end

  // stage 6: sector select into the output register
  logic [CH_W-1:0] ro, go, bo;

  always_comb begin
    case (sec5)
      3'd0: begin ro = mx5; go = t5;  bo = p5;  end
      3'd1: begin ro = q5;  go = mx5; bo = p5;  end
      3'd2: begin ro = p5;  go = mx5; bo = t5;  end
      3'd3: begin ro = p5;  go = q5;  bo = mx5; end
      3'd4: begin ro = t5;  go = p5;  bo = mx5; end
      default: begin ro = mx5; go = p5; bo = q5; end
    endcase
    if (!nz5) begin
      ro = mx5; go = mx5; bo = mx5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      red   <= ro;
      green <= go;
      blue  <= bo;
    end
  end

  // new saturation never exceeds 1.0
  a_ns_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ns3 <= Q_W'(65536)) else $error("saturation above one");

  // hue sector stays within 0..5 once assembled
  a_sector: assert property (@(posedge clk) disable iff (rst)
    v4 |-> sec4 <= 3'd5) else $error("hue sector out of range");

  // p never exceeds value
  a_p_le_v: assert property (@(posedge clk) disable iff (rst)
    v5 |-> p5 <= mx5) else $error("p above value");

  // first and last back-end stages empty right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !v6 && !v1) else $error("valid after reset");

endmodule

`default_nettype wire

FILE: rtl/hsv_saturation_adjust.sv
// Top level of the HSV saturation adjust block: config registers and pipeline.
// Depends on hsa_pkg, hsa_front, hsa_div, hsa_back.
//
// Takes one RGB pixel per clock while the output is not stalled, goes to HSV,
// replaces saturation s with (vibrance + saturation) + (1 - vibrance) * s
// clamped to [0,1], and goes back to RGB. Throughput is one pixel per cycle
// when the output does not stall. The pipeline has 24 register stages: 1 front
// stage, 17 divider stages with one quotient bit each, 6 back-end stages.
// Stalls on the output collapse bubbles in the pipeline. Registers: index 0
// vibrance_gain, index 1 saturation_offset, both signed Q2.16; write them only
// while no pixel is in flight.
`default_nettype none

module hsv_saturation_adjust
  import hsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [47:0]      s_tdata,   // red_in, green_in, blue_in
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [47:0]           m_tdata,   // red_out, green_out, blue_out
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIBRANCE:   cfg.vib <= cfg_data;
        REG_SATURATION: cfg.sat <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                 f_valid, f_ready, d_valid, d_ready, h_inexact;
  side_t                f_side, d_side;
  logic [1:0][CH_W-1:0] f_num, f_den;
  logic [1:0][Q_W-1:0]  d_quo;

  hsa_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .red(s_tdata[15:0]), .green(s_tdata[31:16]), .blue(s_tdata[47:32]),
    .out_valid(f_valid), .out_ready(f_ready),
    .side(f_side), .num(f_num), .den(f_den)
  );

  hsa_div u_div (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready),
    .in_side(f_side), .num(f_num), .den(f_den),
    .out_valid(d_valid), .out_ready(d_ready),
    .out_side(d_side), .quo(d_quo), .hue_inexact(h_inexact)
  );

  hsa_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(d_valid), .in_ready(d_ready),
    .side(d_side), .quo(d_quo), .hue_inexact(h_inexact),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .red(m_tdata[15:0]), .green(m_tdata[31:16]), .blue(m_tdata[47:32])
  );

endmodule

`default_nettype wire
